// File: hdl/lrrs_pkg.sv
package lrrs_pkg;

   // Operating modes carried in req_tuser.
   localparam logic [1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [1:0] MODE_SEND    = 2'd1;
   localparam logic [1:0] MODE_ACK     = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   // Result kinds carried in rsp_tuser.
   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_DROPPED  = 3'd1;
   localparam logic [2:0] KIND_SENT     = 3'd2;
   localparam logic [2:0] KIND_END      = 3'd3;
   localparam logic [2:0] KIND_ACKED    = 3'd4;
   localparam logic [2:0] KIND_ACK_DONE = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] REG_LIMIT0 = 2'd0;
   localparam logic [1:0] REG_LIMIT1 = 2'd1;
   localparam logic [1:0] REG_LIMIT2 = 2'd2;

   localparam int NUM_LEVELS   = 3;
   localparam int NUM_CHANNELS = 7;
   localparam logic [1:0] LAST_STAGE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ENQ,
      ST_SEND_CH,
      ST_REFILL_TEST,
      ST_REFILL_CHK,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_END_OUT,
      ST_ACK_CH,
      ST_ACK_RD,
      ST_ACK_OUT,
      ST_ACK_DONE
   } state_type;

   typedef enum logic [2:0] {
      SRC_ENQ,
      SRC_SENT,
      SRC_END,
      SRC_ACKED,
      SRC_DONE
   } src_type;

   typedef struct packed {
      logic    latch;
      logic    stage_inc;
      logic    rec_first;
      logic    fifo_rd;
      logic    take;
      logic    idx_clr;
      logic    inf_rd;
      logic    emit;
      src_type src;
      logic    last;
      logic    clear_ch;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] mode;
      logic       ch_empty;
      logic       ch_full;
      logic       fifo_avail;
      logic       fit_ok;
      logic       idx_done;
      logic       ack_hit;
      logic       last_stage;
   } status_type;

endpackage

// File: hdl/lrrs_ctrl.sv
module lrrs_ctrl
   import lrrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (status.mode)
               MODE_ENQUEUE: state_in = ST_ENQ;
               MODE_SEND:    state_in = ST_SEND_CH;
               MODE_ACK:     state_in = ST_ACK_CH;
               default:      state_in = ST_IDLE;
            endcase
         end
         ST_ENQ: begin
            if (!status.busy) state_in = ST_IDLE;
         end
         ST_SEND_CH: begin
            state_in = status.ch_empty ? ST_REFILL_TEST : ST_EMIT_RD;
         end
         ST_REFILL_TEST: begin
            state_in = (status.fifo_avail && !status.ch_full) ? ST_REFILL_CHK : ST_EMIT_RD;
         end
         ST_REFILL_CHK: begin
            state_in = status.fit_ok ? ST_REFILL_TEST : ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = status.idx_done ? ST_END_OUT : ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!status.busy) state_in = ST_EMIT_RD;
         end
         ST_END_OUT: begin
            if (!status.busy) state_in = status.last_stage ? ST_IDLE : ST_SEND_CH;
         end
         ST_ACK_CH: begin
            state_in = status.ack_hit ? ST_ACK_RD : ST_ACK_DONE;
         end
         ST_ACK_RD: begin
            state_in = status.idx_done ? ST_ACK_DONE : ST_ACK_OUT;
         end
         ST_ACK_OUT: begin
            if (!status.busy) state_in = ST_ACK_RD;
         end
         ST_ACK_DONE: begin
            if (!status.busy) state_in = status.last_stage ? ST_IDLE : ST_ACK_CH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.src    = SRC_ENQ;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         ST_DECODE: begin
         end
         ST_ENQ: begin
            cmd.emit = !status.busy;
            cmd.src  = SRC_ENQ;
            cmd.last = 1'b1;
         end
         ST_SEND_CH: begin
            cmd.idx_clr   = 1'b1;
            cmd.rec_first = status.ch_empty;
         end
         ST_REFILL_TEST: begin
            cmd.fifo_rd = status.fifo_avail && !status.ch_full;
         end
         ST_REFILL_CHK: begin
            cmd.take = status.fit_ok;
         end
         ST_EMIT_RD, ST_ACK_RD: begin
            cmd.inf_rd = !status.idx_done;
         end
         ST_EMIT_OUT: begin
            cmd.emit = !status.busy;
            cmd.src  = SRC_SENT;
         end
         ST_END_OUT: begin
            cmd.emit      = !status.busy;
            cmd.src       = SRC_END;
            cmd.last      = status.last_stage;
            cmd.stage_inc = !status.busy && !status.last_stage;
         end
         ST_ACK_CH: begin
            cmd.idx_clr = 1'b1;
         end
         ST_ACK_OUT: begin
            cmd.emit = !status.busy;
            cmd.src  = SRC_ACKED;
         end
         ST_ACK_DONE: begin
            cmd.emit      = !status.busy;
            cmd.src       = SRC_DONE;
            cmd.last      = status.last_stage;
            cmd.clear_ch  = !status.busy && status.ack_hit;
            cmd.stage_inc = !status.busy && !status.last_stage;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hdl/lrrs_datapath.sv
module lrrs_datapath
   import lrrs_pkg::*;
#(
   parameter int LEVEL_FIFO_DEPTH = 16,
   parameter int INFLIGHT_DEPTH   = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [11:0] csr_wdata,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int FCW    = $clog2(LEVEL_FIFO_DEPTH + 1);
   localparam int FPW    = $clog2(LEVEL_FIFO_DEPTH);
   localparam int FAW    = $clog2(NUM_LEVELS * LEVEL_FIFO_DEPTH);
   localparam int ICW    = $clog2(INFLIGHT_DEPTH + 1);
   localparam int IAW    = $clog2(NUM_CHANNELS * INFLIGHT_DEPTH);
   localparam int FDEPTH = NUM_LEVELS * LEVEL_FIFO_DEPTH;
   localparam int IDEPTH = NUM_CHANNELS * INFLIGHT_DEPTH;

   logic [11:0]    limit_ff [NUM_LEVELS];
   logic [20:0]    fifo_mem [FDEPTH];
   logic [20:0]    fifo_rdata_ff;
   logic [FCW-1:0] fcount_ff [NUM_LEVELS];
   logic [FPW-1:0] fhead_ff  [NUM_LEVELS];
   logic [19:0]    inf_mem [IDEPTH];
   logic [19:0]    inf_rdata_ff;
   logic [ICW-1:0] icount_ff [NUM_CHANNELS];
   logic [12:0]    itotal_ff [NUM_CHANNELS];
   logic [31:0]    first_ff  [NUM_CHANNELS];

   logic [1:0]     mode_ff;
   logic [1:0]     level_ff;
   logic [7:0]     tag_ff;
   logic [11:0]    bits_ff;
   logic           allow_ff;
   logic [31:0]    packet_ff;
   logic [1:0]     stage_ff;
   logic [ICW-1:0] idx_ff;
   logic [15:0]    ser_ff;

   logic           rsp_valid_ff;
   logic [39:0]    rsp_data_ff;
   logic [2:0]     rsp_kind_ff;
   logic           rsp_last_ff;

   logic [2:0]     chan;
   logic [1:0]     chan_sub;
   logic           enq_ok;
   logic [FPW:0]   push_sum;
   logic [FPW-1:0] push_pos;
   logic [FPW-1:0] head_next;
   logic [FAW-1:0] push_addr;
   logic [FAW-1:0] pop_addr;
   logic [IAW-1:0] take_addr;
   logic [IAW-1:0] read_addr;
   logic [13:0]    fit_sum;
   logic [2:0]     out_kind;
   logic [39:0]    out_data;

   // Channel visited at the current stage: level 0 has one channel, level 1 two, level 2 four.
   always_comb begin
      case (stage_ff)
         2'd0:    chan_sub = 2'd0;
         2'd1:    chan_sub = {1'b0, packet_ff[0]};
         default: chan_sub = packet_ff[1:0];
      endcase
      case (stage_ff)
         2'd0:    chan = 3'd0;
         2'd1:    chan = 3'd1 + {2'b0, packet_ff[0]};
         default: chan = 3'd3 + {1'b0, packet_ff[1:0]};
      endcase
   end

   assign enq_ok   = (level_ff != 2'd3) && (fcount_ff[level_ff] != FCW'(LEVEL_FIFO_DEPTH));
   assign push_sum = (FPW+1)'(fhead_ff[level_ff]) + (FPW+1)'(fcount_ff[level_ff]);
   assign push_pos = (push_sum >= (FPW+1)'(LEVEL_FIFO_DEPTH)) ?
                     FPW'(push_sum - (FPW+1)'(LEVEL_FIFO_DEPTH)) : FPW'(push_sum);
   assign head_next = (fhead_ff[stage_ff] == FPW'(LEVEL_FIFO_DEPTH - 1)) ?
                      '0 : fhead_ff[stage_ff] + FPW'(1);
   assign push_addr = FAW'(FAW'(level_ff) * FAW'(LEVEL_FIFO_DEPTH) + FAW'(push_pos));
   assign pop_addr  = FAW'(FAW'(stage_ff) * FAW'(LEVEL_FIFO_DEPTH) + FAW'(fhead_ff[stage_ff]));
   assign take_addr = IAW'(IAW'(chan) * IAW'(INFLIGHT_DEPTH) + IAW'(icount_ff[chan]));
   assign read_addr = IAW'(IAW'(chan) * IAW'(INFLIGHT_DEPTH) + IAW'(idx_ff));
   assign fit_sum   = {1'b0, itotal_ff[chan]} + {2'b0, fifo_rdata_ff[19:8]};

   assign status.busy       = rsp_valid_ff && !rsp_tready;
   assign status.mode       = mode_ff;
   assign status.ch_empty   = icount_ff[chan] == '0;
   assign status.ch_full    = icount_ff[chan] == ICW'(INFLIGHT_DEPTH);
   assign status.fifo_avail = fcount_ff[stage_ff] != '0;
   assign status.fit_ok     = (fit_sum < {2'b0, limit_ff[stage_ff]}) ||
                              (fifo_rdata_ff[20] && icount_ff[chan] == '0);
   assign status.idx_done   = idx_ff == icount_ff[chan];
   assign status.ack_hit    = packet_ff >= first_ff[chan];
   assign status.last_stage = stage_ff == LAST_STAGE;

   // Result fields: level, channel, tag, bits, channel bits from the lowest bit up.
   always_comb begin
      out_kind = KIND_DROPPED;
      out_data = '0;
      case (cmd.src)
         SRC_ENQ: begin
            out_kind = enq_ok ? KIND_ACCEPTED : KIND_DROPPED;
            out_data = {16'd0, bits_ff, tag_ff, 2'd0, level_ff};
         end
         SRC_SENT: begin
            out_kind = KIND_SENT;
            out_data = {16'd0, inf_rdata_ff[19:8], inf_rdata_ff[7:0], chan_sub, stage_ff};
         end
         SRC_END: begin
            out_kind = KIND_END;
            out_data = {ser_ff + 16'd1, 20'd0, chan_sub, stage_ff};
         end
         SRC_ACKED: begin
            out_kind = KIND_ACKED;
            out_data = {16'd0, inf_rdata_ff[19:8], inf_rdata_ff[7:0], chan_sub, stage_ff};
         end
         SRC_DONE: begin
            out_kind = KIND_ACK_DONE;
            out_data = {(status.ack_hit ? {3'd0, itotal_ff[chan]} : 16'd0),
                        20'd0, chan_sub, stage_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= req_tuser;
         level_ff  <= req_tdata[1:0];
         tag_ff    <= req_tdata[9:2];
         bits_ff   <= req_tdata[21:10];
         allow_ff  <= req_tdata[22];
         packet_ff <= req_tdata[54:23];
         stage_ff  <= '0;
      end else if (cmd.stage_inc) begin
         stage_ff <= stage_ff + 2'd1;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
         ser_ff <= '0;
      end else begin
         if (cmd.inf_rd) idx_ff <= idx_ff + ICW'(1);
         if (cmd.emit && cmd.src == SRC_SENT) begin
            ser_ff <= ser_ff + 16'd1 + {4'd0, inf_rdata_ff[19:8]};
         end
      end
      if (cmd.emit) begin
         rsp_data_ff <= out_data;
         rsp_kind_ff <= out_kind;
         rsp_last_ff <= cmd.last;
      end
   end

   // Level FIFO storage.
   always_ff @(posedge clock) begin
      if (cmd.emit && cmd.src == SRC_ENQ && enq_ok) begin
         fifo_mem[push_addr] <= {allow_ff, bits_ff, tag_ff};
      end
      if (cmd.fifo_rd) fifo_rdata_ff <= fifo_mem[pop_addr];
   end

   // In-flight storage.
   always_ff @(posedge clock) begin
      if (cmd.take) inf_mem[take_addr] <= fifo_rdata_ff[19:0];
      if (cmd.inf_rd) inf_rdata_ff <= inf_mem[read_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff[0]  <= 12'd160;
         limit_ff[1]  <= 12'd1600;
         limit_ff[2]  <= 12'd1600;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            fcount_ff[i] <= '0;
            fhead_ff[i]  <= '0;
         end
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            icount_ff[i] <= '0;
            itotal_ff[i] <= '0;
            first_ff[i]  <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_LIMIT0: limit_ff[0] <= csr_wdata;
               REG_LIMIT1: limit_ff[1] <= csr_wdata;
               REG_LIMIT2: limit_ff[2] <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit && cmd.src == SRC_ENQ && enq_ok) begin
            fcount_ff[level_ff] <= fcount_ff[level_ff] + FCW'(1);
         end
         if (cmd.rec_first) first_ff[chan] <= packet_ff;
         if (cmd.take) begin
            icount_ff[chan]     <= icount_ff[chan] + ICW'(1);
            itotal_ff[chan]     <= fit_sum[12:0];
            fhead_ff[stage_ff]  <= head_next;
            fcount_ff[stage_ff] <= fcount_ff[stage_ff] - FCW'(1);
         end
         if (cmd.clear_ch) begin
            icount_ff[chan] <= '0;
            itotal_ff[chan] <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   generate
      for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chk_ch
         a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
            icount_ff[g] <= ICW'(INFLIGHT_DEPTH))
            else $error("in-flight count above depth");
      end
      for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk_lv
         a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
            fcount_ff[g] <= FCW'(LEVEL_FIFO_DEPTH))
            else $error("level FIFO count above depth");
      end
   endgenerate
   a_take_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> (fcount_ff[stage_ff] != '0 && !status.ch_full))
      else $error("refill from empty FIFO or into full channel");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten while stalled");
`endif

endmodule

// File: hdl/leveled_reliable_resend_scheduler_top.sv
// Leveled reliable resend scheduler.
// The req_ channel carries one transaction per command: req_tuser selects enqueue, send
// or acknowledge, and req_tdata carries level, tag, size, allow flag and packet number.
// The rsp_ channel returns the results of each command in order; rsp_tuser gives the
// result kind and rsp_tlast marks the final result of the command.
// The csr_ port writes the three per-level bit budgets; write only while the block idles.
// Commands are handled one at a time. A send visits three channels, one per level; an
// empty channel first refills from its level FIFO, and a result is then emitted for
// every stored action, each of which passes through a memory with a registered read port
// (at most eight actions per channel with the default depth). An acknowledge emits one
// result per released action plus one per channel, and clears a channel it releases.
// req_tready is high only while the controller waits for a command.
// A single output register holds the pending result; when the receiver stalls, the
// controller waits and resumes as soon as that result is taken, so nothing is lost.
// Reset restores the default budgets and empties all FIFOs and channels.
module leveled_reliable_resend_scheduler_top
   import lrrs_pkg::*;
#(
   parameter int LEVEL_FIFO_DEPTH = 16,
   parameter int INFLIGHT_DEPTH   = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // level, action_tag, action_bits, allow_exceed, packet_number
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_level, out_channel, out_tag, out_bits, channel_bits
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences channel visits; the datapath owns all storage.
   lrrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lrrs_datapath #(
      .LEVEL_FIFO_DEPTH (LEVEL_FIFO_DEPTH),
      .INFLIGHT_DEPTH   (INFLIGHT_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
